// ----- sv/per_integer_encoder_macros.svh -----
// assertion macros for the aligned per integer encoder
`ifndef PER_INTEGER_ENCODER_MACROS_SVH
`define PER_INTEGER_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define PER_ASSERT(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("per encoder check failed");
`define PER_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("per encoder sequence check failed");
`else
`define PER_ASSERT(name, expr)
`define PER_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- sv/per_pkg.sv -----
// shared types, codes and helper functions of the per integer encoder
package per_pkg;

    localparam logic [2:0] REQ_CONSTRAINED = 3'd0;
    localparam logic [2:0] REQ_SEMI        = 3'd1;
    localparam logic [2:0] REQ_UNCONSTR    = 3'd2;
    localparam logic [2:0] REQ_LENGTH      = 3'd3;
    localparam logic [2:0] REQ_SMALL       = 3'd4;

    localparam logic [63:0] LEN_SHORT_MAX = 64'd127;
    localparam logic [63:0] LEN_LONG_MAX  = 64'd16383;
    localparam logic [63:0] SMALL_MAX     = 64'd63;
    localparam logic [63:0] SMALL_EXT_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] BYTE_RANGE_MAX = 64'd254;
    localparam logic [63:0] WORD_RANGE_MAX = 64'd65535;

    typedef struct packed {
        logic [2:0]  req;
        logic [63:0] v;
        logic [63:0] diff;
        logic [63:0] offset;
        logic        err;
    } per_s1_t;

    typedef struct packed {
        logic [2:0]  req;
        logic [63:0] v;
        logic [63:0] offset;
        logic        err;
        logic        le1;
        logic        lt256;
        logic        le64k;
        logic [6:0]  bitsr;
        logic [3:0]  oct_off;
        logic [3:0]  oct_v;
        logic [3:0]  ulen;
        logic        v_small;
        logic        v_short;
    } per_s2_t;

    typedef struct packed {
        logic        p0_en;
        logic [7:0]  p0_val;
        logic [3:0]  p0_bits;
        logic        p0_align;
        logic        p1_en;
        logic [7:0]  p1_val;
        logic        status;
        logic [63:0] body;
        logic [3:0]  nbytes;
    } per_desc_t;

    // bit length of a word, zero for zero
    function automatic logic [6:0] bit_len(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
                n = 7'(i + 1);
        end
        return n;
    endfunction

    // octets needed for an unsigned word, at least one
    function automatic logic [3:0] min_octets(input logic [63:0] x);
        logic [3:0] n;
        n = 4'd1;
        for (int i = 0; i < 8; i++)
        begin
            if (x[i*8 +: 8] != 8'd0)
                n = 4'(i + 1);
        end
        return n;
    endfunction

    // bits for a constrained count in 1 to n, n at most 8
    function automatic logic [3:0] count_bits(input logic [3:0] n);
        logic [3:0] b;
        if (n <= 4'd1)
            b = 4'd0;
        else if (n == 4'd2)
            b = 4'd1;
        else if (n <= 4'd4)
            b = 4'd2;
        else
            b = 4'd3;
        return b;
    endfunction

endpackage

// ----- sv/per_front.sv -----
// stage one: bound compares, range span and offset
module per_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic signed [63:0]  value,
    input  logic signed [63:0]  lo_bound,
    input  logic signed [63:0]  hi_bound,
    output logic                out_valid,
    input  logic                out_stall,
    output per_pkg::per_s1_t    out_data
);
    import per_pkg::*;

    logic    valid_reg;
    per_s1_t data_reg;
    per_s1_t data_next;
    logic    adv;

    assign adv      = !valid_reg || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        data_next.req    = req_type;
        data_next.v      = value;
        data_next.diff   = hi_bound - lo_bound;
        data_next.offset = value - lo_bound;
        case (req_type)
            REQ_CONSTRAINED: data_next.err = (value < lo_bound) || (hi_bound < value);
            REQ_SEMI:        data_next.err = (value < lo_bound);
            default:         data_next.err = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ----- sv/per_classify.sv -----
// stage two: range class, bit and octet counts, limit checks
module per_classify (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  per_pkg::per_s1_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output per_pkg::per_s2_t    out_data
);
    import per_pkg::*;

    logic    valid_reg;
    per_s2_t data_reg;
    per_s2_t data_next;
    logic    adv;
    logic    fits1;
    logic    fits2;
    logic    fits3;
    logic    fits4;

    assign adv      = !valid_reg || !out_stall;
    assign in_stall = !adv;

    // sign extension checks for the two's complement length
    assign fits1 = (&in_data.v[63:7])  || !(|in_data.v[63:7]);
    assign fits2 = (&in_data.v[63:15]) || !(|in_data.v[63:15]);
    assign fits3 = (&in_data.v[63:23]) || !(|in_data.v[63:23]);
    assign fits4 = (&in_data.v[63:31]) || !(|in_data.v[63:31]);

    always_comb
    begin
        data_next.req     = in_data.req;
        data_next.v       = in_data.v;
        data_next.offset  = in_data.offset;
        data_next.le1     = (in_data.diff == 64'd0) || (&in_data.diff);
        data_next.lt256   = !data_next.le1 && (in_data.diff <= BYTE_RANGE_MAX);
        data_next.le64k   = in_data.diff <= WORD_RANGE_MAX;
        data_next.bitsr   = bit_len(in_data.diff);
        data_next.oct_off = min_octets(in_data.offset);
        data_next.oct_v   = min_octets(in_data.v);
        data_next.v_small = in_data.v <= SMALL_MAX;
        data_next.v_short = in_data.v <= LEN_SHORT_MAX;
        if (fits1)
            data_next.ulen = 4'd1;
        else if (fits2)
            data_next.ulen = 4'd2;
        else if (fits3)
            data_next.ulen = 4'd3;
        else if (fits4)
            data_next.ulen = 4'd4;
        else
            data_next.ulen = 4'd8;
        case (in_data.req)
            REQ_CONSTRAINED,
            REQ_SEMI,
            REQ_UNCONSTR: data_next.err = in_data.err;
            REQ_LENGTH:   data_next.err = in_data.v > LEN_LONG_MAX;
            REQ_SMALL:    data_next.err = in_data.v > SMALL_EXT_MAX;
            default:      data_next.err = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ----- sv/per_build.sv -----
// stage three: segment plan with prefix segments and left aligned octets
module per_build (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  per_pkg::per_s2_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output per_pkg::per_desc_t  out_data
);
    import per_pkg::*;

    logic      valid_reg;
    per_desc_t data_reg;
    per_desc_t data_next;
    logic      adv;
    logic [3:0]  maxlen;
    logic [3:0]  clen;
    logic [63:0] src;
    logic [5:0]  shamt;

    assign adv      = !valid_reg || !out_stall;
    assign in_stall = !adv;

    assign maxlen = 4'((in_data.bitsr + 7'd7) >> 3);
    assign clen   = (in_data.oct_off > maxlen) ? maxlen : in_data.oct_off;

    always_comb
    begin
        data_next.p0_en    = 1'b0;
        data_next.p0_val   = 8'd0;
        data_next.p0_bits  = 4'd0;
        data_next.p0_align = 1'b0;
        data_next.p1_en    = 1'b0;
        data_next.p1_val   = 8'd0;
        data_next.status   = 1'b0;
        data_next.nbytes   = 4'd0;
        src                = in_data.offset;
        if (in_data.err)
        begin
            data_next.p0_en  = 1'b1;
            data_next.status = 1'b1;
        end
        else
        begin
            case (in_data.req)
                REQ_CONSTRAINED:
                begin
                    if (in_data.le1)
                        data_next.p0_en = 1'b1;
                    else if (in_data.lt256)
                    begin
                        data_next.p0_en   = 1'b1;
                        data_next.p0_val  = in_data.offset[7:0];
                        data_next.p0_bits = 4'(in_data.bitsr);
                    end
                    else if (in_data.le64k)
                        data_next.nbytes = maxlen;
                    else
                    begin
                        data_next.p0_en   = 1'b1;
                        data_next.p0_val  = 8'(clen - 4'd1);
                        data_next.p0_bits = count_bits(maxlen);
                        data_next.nbytes  = clen;
                    end
                end
                REQ_SEMI:
                begin
                    data_next.p1_en  = 1'b1;
                    data_next.p1_val = 8'(in_data.oct_off);
                    data_next.nbytes = in_data.oct_off;
                end
                REQ_UNCONSTR:
                begin
                    data_next.p0_en    = 1'b1;
                    data_next.p0_val   = 8'(in_data.ulen);
                    data_next.p0_bits  = 4'd8;
                    data_next.p0_align = 1'b1;
                    data_next.nbytes   = in_data.ulen;
                    src                = in_data.v;
                end
                REQ_LENGTH:
                begin
                    data_next.p0_en    = 1'b1;
                    data_next.p0_bits  = 4'd8;
                    data_next.p0_align = 1'b1;
                    if (in_data.v_short)
                        data_next.p0_val = in_data.v[7:0];
                    else
                    begin
                        data_next.p0_val = in_data.v[15:8] | 8'h80;
                        data_next.p1_en  = 1'b1;
                        data_next.p1_val = in_data.v[7:0];
                    end
                end
                default:
                begin
                    data_next.p0_en = 1'b1;
                    if (in_data.v_small)
                    begin
                        data_next.p0_val  = in_data.v[7:0];
                        data_next.p0_bits = 4'd7;
                    end
                    else
                    begin
                        // extension bit, then semi-constrained with bound zero
                        data_next.p0_val  = 8'd1;
                        data_next.p0_bits = 4'd1;
                        data_next.p1_en   = 1'b1;
                        data_next.p1_val  = 8'(in_data.oct_v);
                        data_next.nbytes  = in_data.oct_v;
                        src               = in_data.v;
                    end
                end
            endcase
        end
        shamt          = {3'(4'd8 - data_next.nbytes), 3'b000};
        data_next.body = src << shamt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ----- sv/per_emit.sv -----
// segment emitter: walks one plan, one segment per cycle while seg_stall is low
`include "per_integer_encoder_macros.svh"
module per_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  per_pkg::per_desc_t  in_data,
    output logic                seg_valid,
    input  logic                seg_stall,
    output logic [7:0]          seg_value,
    output logic [3:0]          seg_bits,
    output logic                align_before,
    output logic                status,
    output logic                last
);
    import per_pkg::*;

    logic      busy_reg;
    per_desc_t desc_reg;
    per_desc_t desc_next;
    logic      fire;
    logic      load;
    logic      last_c;

    always_comb
    begin
        desc_next = desc_reg;
        if (desc_reg.p0_en)
        begin
            seg_value    = desc_reg.p0_val;
            seg_bits     = desc_reg.p0_bits;
            align_before = desc_reg.p0_align;
            last_c       = !desc_reg.p1_en && (desc_reg.nbytes == 4'd0);
            desc_next.p0_en = 1'b0;
        end
        else if (desc_reg.p1_en)
        begin
            seg_value    = desc_reg.p1_val;
            seg_bits     = 4'd8;
            align_before = 1'b1;
            last_c       = desc_reg.nbytes == 4'd0;
            desc_next.p1_en = 1'b0;
        end
        else
        begin
            seg_value    = desc_reg.body[63:56];
            seg_bits     = 4'd8;
            align_before = 1'b1;
            last_c       = desc_reg.nbytes <= 4'd1;
            desc_next.body   = {desc_reg.body[55:0], 8'd0};
            desc_next.nbytes = desc_reg.nbytes - 4'd1;
        end
    end

    assign fire     = busy_reg && !seg_stall;
    assign load     = !busy_reg || (fire && last_c);
    assign in_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (load)
            busy_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            desc_reg <= in_data;
        else if (fire)
            desc_reg <= desc_next;
    end

    assign seg_valid = busy_reg;
    assign status    = desc_reg.status;
    assign last      = last_c;

    `PER_ASSERT(a_bits_range, !busy_reg || (seg_bits <= 4'd8))
    `PER_ASSERT(a_error_alone, !busy_reg || !desc_reg.status || last_c)
    `PER_ASSERT(a_octet_count, !busy_reg || (desc_reg.nbytes <= 4'd8))
    `PER_ASSERT_NEXT(a_hold_busy, busy_reg && seg_stall, busy_reg)
endmodule

// ----- sv/per_integer_encoder.sv -----
// top level of the aligned per integer encoder
//
// channel   handshake              payload
// request   req_valid / req_stall  req_type, value, lo_bound, hi_bound
// segment   seg_valid / seg_stall  seg_value, seg_bits, align_before, status, last
//
// a request passes three register stages (compare, classify, plan) and then the
// emitter register, which offers the segments of the request in order
// the emitter gives one segment a cycle while seg_stall is low; it takes the next
// plan when idle or as the last segment of the current plan is taken
// rst_n clears only the valid bits of the stages and the emitter busy flag
// seg_stall holds the current segment; stalls back up through the stages
// without loss
module per_integer_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         req_type,
    input  logic signed [63:0] value,
    input  logic signed [63:0] lo_bound,
    input  logic signed [63:0] hi_bound,
    output logic               seg_valid,
    input  logic               seg_stall,
    output logic [7:0]         seg_value,
    output logic [3:0]         seg_bits,
    output logic               align_before,
    output logic               status,
    output logic               last
);
    import per_pkg::*;

    // stage one: signed bound checks, span and offset
    per_s1_t   s1_data;
    logic      s1_valid;
    logic      s1_stall;
    // stage two: range class and counts
    per_s2_t   s2_data;
    logic      s2_valid;
    logic      s2_stall;
    // stage three: segment plan
    per_desc_t s3_data;
    logic      s3_valid;
    logic      s3_stall;

    per_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .req_type  (req_type),
        .value     (value),
        .lo_bound  (lo_bound),
        .hi_bound  (hi_bound),
        .out_valid (s1_valid),
        .out_stall (s1_stall),
        .out_data  (s1_data)
    );

    per_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_stall  (s1_stall),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_stall (s2_stall),
        .out_data  (s2_data)
    );

    per_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_stall  (s2_stall),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_stall (s3_stall),
        .out_data  (s3_data)
    );

    // emitter: prefix segments first, then the octets most significant first
    per_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s3_valid),
        .in_stall     (s3_stall),
        .in_data      (s3_data),
        .seg_valid    (seg_valid),
        .seg_stall    (seg_stall),
        .seg_value    (seg_value),
        .seg_bits     (seg_bits),
        .align_before (align_before),
        .status       (status),
        .last         (last)
    );
endmodule

// ----- sim/per_integer_encoder_tb.sv -----
// testbench for the aligned per integer encoder: random and directed requests, scoreboard check
`timescale 1ns / 100ps

module per_integer_encoder_tb;
    import per_pkg::*;

    // request codes with no defined form
    localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [7:0] val;
        logic [3:0] bits;
        logic       align;
        logic       stat;
        logic       lst;
    } segment_t;

    // scoreboard: predicts segments of each accepted request and checks them in order
    class segment_scoreboard;
        segment_t pending[$];
        int       mismatches;
        int       requests;
        int       segments;

        function void put(logic [7:0] v, int b, bit al);
            segment_t s;
            s.val = v;
            s.bits = 4'(b);
            s.align = al;
            s.stat = 1'b0;
            s.lst = 1'b0;
            pending.push_back(s);
        endfunction

        function void put_octets(logic [63:0] v, int cnt);
            for (int i = cnt; i > 0; i--)
                put(v[8*(i-1) +: 8], 8, 1'b1);
        endfunction

        function int octets_of(logic [63:0] v);
            int n;
            n = 1;
            for (int i = 0; i < 8; i++)
                if (v[8*i +: 8] != 8'd0)
                    n = i + 1;
            return n;
        endfunction

        function int width_of_range(logic [63:0] r);
            int n;
            logic [63:0] w;
            n = 0;
            if (r <= 64'd1)
                return 0;
            w = r - 64'd1;
            while (w != 64'd0)
            begin
                w = w >> 1;
                n++;
            end
            return n;
        endfunction

        function void put_error();
            segment_t s;
            s.val = 8'd0;
            s.bits = 4'd0;
            s.align = 1'b0;
            s.stat = 1'b1;
            s.lst = 1'b1;
            pending.push_back(s);
        endfunction

        function void put_semi(logic [63:0] off);
            int len;
            len = octets_of(off);
            put(8'(len), 8, 1'b1);
            put_octets(off, len);
        endfunction

        // note an accepted request and queue its segments
        function void note_request(logic [2:0] rt, logic signed [63:0] v,
                                   logic signed [63:0] lb, logic signed [63:0] ub);
            int          start;
            int          maxlen;
            int          len;
            logic [63:0] range;
            logic [63:0] off;
            logic [63:0] uv;
            start = pending.size();
            uv = v;
            requests++;
            case (rt)
                REQ_CONSTRAINED:
                begin
                    if (v < lb || ub < v)
                    begin
                        put_error();
                        return;
                    end
                    range = ub - lb + 64'd1;
                    off = v - lb;
                    if (range <= 64'd1)
                        put(8'd0, 0, 1'b0);
                    else if (range < 64'd256)
                        put(off[7:0], width_of_range(range), 1'b0);
                    else if (range <= 64'd65536)
                        put_octets(off, (width_of_range(range) + 7) / 8);
                    else
                    begin
                        maxlen = (width_of_range(range) + 7) / 8;
                        len = octets_of(off);
                        if (len > maxlen)
                            len = maxlen;
                        put(8'(len - 1), width_of_range(maxlen), 1'b0);
                        put_octets(off, len);
                    end
                end
                REQ_SEMI:
                begin
                    if (v < lb)
                    begin
                        put_error();
                        return;
                    end
                    put_semi(v - lb);
                end
                REQ_UNCONSTR:
                begin
                    if (uv + 64'h80 < 64'h100)
                        len = 1;
                    else if (uv + 64'h8000 < 64'h10000)
                        len = 2;
                    else if (uv + 64'h80_0000 < 64'h100_0000)
                        len = 3;
                    else if (uv + 64'h8000_0000 < 64'h1_0000_0000)
                        len = 4;
                    else
                        len = 8;
                    put(8'(len), 8, 1'b1);
                    put_octets(uv, len);
                end
                REQ_LENGTH:
                begin
                    if (uv <= LEN_SHORT_MAX)
                        put(uv[7:0], 8, 1'b1);
                    else if (uv <= LEN_LONG_MAX)
                    begin
                        put(uv[15:8] | 8'h80, 8, 1'b1);
                        put(uv[7:0], 8, 1'b1);
                    end
                    else
                    begin
                        put_error();
                        return;
                    end
                end
                REQ_SMALL:
                begin
                    if (uv <= SMALL_MAX)
                        put(uv[7:0], 7, 1'b0);
                    else if (uv <= SMALL_EXT_MAX)
                    begin
                        put(8'd1, 1, 1'b0);
                        put_semi(uv);
                    end
                    else
                    begin
                        put_error();
                        return;
                    end
                end
                default:
                begin
                    put_error();
                    return;
                end
            endcase
            pending[pending.size() - 1].lst = 1'b1;
            if (pending.size() == start)
                $display("internal: no segment predicted");
        endfunction

        // compare one accepted segment with the oldest prediction
        function void check_segment(segment_t got);
            segment_t want;
            segments++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected segment val=%h bits=%0d", got.val, got.bits);
                return;
            end
            want = pending.pop_front();
            if (got.val !== want.val || got.bits !== want.bits || got.align !== want.align
                || got.stat !== want.stat || got.lst !== want.lst)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("segment mismatch: want val=%h bits=%0d al=%b st=%b last=%b",
                             want.val, want.bits, want.align, want.stat, want.lst);
                    $display("                  got  val=%h bits=%0d al=%b st=%b last=%b",
                             got.val, got.bits, got.align, got.stat, got.lst);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [2:0]         req_type;
    logic signed [63:0] value;
    logic signed [63:0] lo_bound;
    logic signed [63:0] hi_bound;
    logic               seg_valid;
    logic               seg_stall;
    logic [7:0]         seg_value;
    logic [3:0]         seg_bits;
    logic               align_before;
    logic               status;
    logic               last;

    segment_scoreboard board;
    int  send_idle_pct;    // sender gap chance in percent
    int  recv_stall_pct;   // receiver stall chance in percent
    bit  hold_off;         // long receiver hold-off in progress

    per_integer_encoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .value(value),
        .lo_bound(lo_bound),
        .hi_bound(hi_bound),
        .seg_valid(seg_valid),
        .seg_stall(seg_stall),
        .seg_value(seg_value),
        .seg_bits(seg_bits),
        .align_before(align_before),
        .status(status),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // overall watchdog
    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // random 64-bit word
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // send one request: idle at random, then wait for acceptance
    task automatic send_request(logic [2:0] rt, logic [63:0] v, logic [63:0] lb,
                                logic [63:0] ub);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= rt;
        value <= v;
        lo_bound <= lb;
        hi_bound <= ub;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(rt, v, lb, ub);
    endtask

    // random request, mostly well-formed with small sizes
    task automatic send_random();
        logic [2:0]  rt;
        logic [63:0] lb;
        logic [63:0] span;
        logic [63:0] v;
        int          pick;
        rt = 3'($urandom_range(4));
        if ($urandom_range(19) == 0)
            rt = 3'($urandom_range(7));
        lb = rand64() >>> $urandom_range(63);
        pick = $urandom_range(3);
        span = (pick == 0) ? 64'($urandom_range(255)) :
               (pick == 1) ? 64'($urandom_range(70000)) : rand64() >> $urandom_range(63);
        v = lb + (span == 0 ? 64'd0 : rand64() % (span + 64'd1));
        if ($urandom_range(9) == 0)
            v = rand64();
        if (rt == REQ_LENGTH)
            v = $urandom_range(3) == 0 ? rand64() >> $urandom_range(63)
                                       : 64'($urandom_range(17000));
        if (rt == REQ_SMALL)
            v = $urandom_range(1) ? 64'($urandom_range(80)) : rand64() >> $urandom_range(63);
        if (rt == REQ_UNCONSTR)
            v = rand64() >>> $urandom_range(63);
        send_request(rt, v, lb, lb + span);
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_stall <= 1'b0;
        else
            seg_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // segment monitor
    always @(posedge clk)
    begin
        segment_t s;
        if (rst_n && seg_valid && !seg_stall)
        begin
            s.val = seg_value;
            s.bits = seg_bits;
            s.align = align_before;
            s.stat = status;
            s.lst = last;
            board.check_segment(s);
        end
    end

    // long hold-off of the receiver, counted in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (board != null && board.requests == 20);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [63:0] smin;
        logic [63:0] smax;
        board = new();
        smin = 64'h8000_0000_0000_0000;
        smax = 64'h7FFF_FFFF_FFFF_FFFF;
        send_idle_pct = 10;
        recv_stall_pct = 46;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = REQ_CONSTRAINED;
        value = '0;
        lo_bound = '0;
        hi_bound = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and every special case
        send_request(REQ_CONSTRAINED, 64'd5, 64'd5, 64'd5);         // range of one
        send_request(REQ_CONSTRAINED, 64'd3, 64'd4, 64'd9);         // below bound
        send_request(REQ_CONSTRAINED, 64'd10, 64'd4, 64'd9);        // above bound
        send_request(REQ_CONSTRAINED, 64'd5, 64'd9, 64'd4);         // inverted bounds
        send_request(REQ_CONSTRAINED, smax, smin, smax);            // full span wraps
        send_request(REQ_CONSTRAINED, 64'd200, 64'd0, 64'd254);     // bit field
        send_request(REQ_CONSTRAINED, 64'd255, 64'd0, 64'd255);     // one octet
        send_request(REQ_CONSTRAINED, 64'd65535, 64'd0, 64'd65535); // two octets
        send_request(REQ_CONSTRAINED, smin, smin, smax - 64'd1);    // length + content
        send_request(REQ_CONSTRAINED, smax - 64'd1, smin, smax - 64'd1);
        send_request(REQ_SEMI, smax, smin, 64'd0);
        send_request(REQ_SEMI, 64'd0, 64'd1, 64'd0);                 // below bound
        send_request(REQ_UNCONSTR, 64'h7F, 64'd0, 64'd0);
        send_request(REQ_UNCONSTR, -64'sd8388608, 64'd0, 64'd0);
        send_request(REQ_UNCONSTR, 64'd2147483647, 64'd0, 64'd0);
        send_request(REQ_UNCONSTR, smin, 64'd0, 64'd0);
        send_request(REQ_LENGTH, 64'd127, 64'd0, 64'd0);
        send_request(REQ_LENGTH, 64'd16383, 64'd0, 64'd0);
        send_request(REQ_LENGTH, 64'd16384, 64'd0, 64'd0);
        send_request(REQ_SMALL, 64'd63, 64'd0, 64'd0);
        send_request(REQ_SMALL, 64'hFFFF_FFFF, 64'd0, 64'd0);
        send_request(REQ_SMALL, 64'h1_0000_0000, 64'd0, 64'd0);
        send_request(REQ_RESERVED_FIRST, 64'd0, 64'd0, 64'd0);
        send_request(REQ_RESERVED_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF);

        // random phases with swapped idling, then full rate
        repeat (35) send_random();
        send_idle_pct = 46;
        recv_stall_pct = 10;
        repeat (35) send_random();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (35) send_random();
        req_valid <= 1'b0;

        wait_drained();
        $display("covered %0d requests and %0d segments over all five forms and errors",
                 board.requests, board.segments);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
